// File: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, quiet while reset is asserted (active low).
`define HLC_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
    else $error("hlc assertion failed");

// Clocked assertion that is also checked through reset.
`define HLC_ASSERT_NORST(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("hlc reset assertion failed");

`endif

// File: hw/rtl/hlc_pkg.sv
package hlc_pkg;

  localparam int unsigned HASH_BITS = 8;
  localparam int unsigned BUCKET_COUNT_DEF = 1 << HASH_BITS;
  localparam int unsigned WAYS_PER_BUCKET_DEF = 4;
  localparam int unsigned KEY_W = 64;
  localparam int unsigned IDX_W = 32;

  // action codes
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_LOOKUP = 2'd1;
  localparam logic [1:0] ACT_DELETE = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISS    = 2'd1;
  localparam logic [1:0] ST_PRESENT = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [1:0]       action;
    logic [KEY_W-1:0] seq_key;
    logic [IDX_W-1:0] server_index;
  } hlc_in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] found_index;
  } hlc_out_t;

  typedef struct packed {
    logic row_we;
    logic entry_we;
  } hlc_mem_ctl_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_ROW,
    S_ISSUE,
    S_CMP,
    S_EXEC,
    S_DONE
  } hlc_state_t;

endpackage

// File: hw/rtl/hashed_location_cache_top.sv
// Hashed location cache: maps a 64-bit sequence key to a 32-bit server index.
// Input channel (in_valid / in_stall / in_data) carries one request transaction:
// action (insert, lookup, delete), seq_key and server_index. Result channel
// (out_valid / out_stall / out_data) returns exactly one transaction per request:
// status and found_index (nonzero only on a lookup hit).
// Requests are handled one at a time; in_stall stays high while a request is in
// work. With a power-of-two bucket count a request passes S_ROW, then S_ISSUE and
// S_CMP per way scanned (1..WAYS, stop at the first match), then S_EXEC, and waits
// in S_DONE until the output register takes its result; only then is a new request
// taken. The way scan through the single key/value memory port and the one 64-bit
// comparator limits the request rate. Other bucket counts add S_HASH first: the key
// residue is built from four 16-bit chunks, each by a quotient and a remainder step.
// Reset: a clearing pass writes every bucket's valid row to zero, one bucket per
// cycle (BUCKET_COUNT buckets, 256 by default), with in_stall high throughout.
// Stall: a result waits in the output register while out_stall is high; the
// next request is still accepted and worked on, and its result holds inside the
// sequencer until the output register frees up.
module hashed_location_cache_top #(
  parameter int unsigned BUCKET_COUNT    = hlc_pkg::BUCKET_COUNT_DEF,
  parameter int unsigned WAYS_PER_BUCKET = hlc_pkg::WAYS_PER_BUCKET_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  hlc_pkg::hlc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output hlc_pkg::hlc_out_t out_data
);
  import hlc_pkg::*;

  localparam int unsigned BUCKET_BITS = $clog2(BUCKET_COUNT);
  localparam int unsigned ENTRY_BITS  = $clog2(BUCKET_COUNT * WAYS_PER_BUCKET);

  hlc_mem_ctl_t               mem_ctl;
  logic [BUCKET_BITS-1:0]     row_addr;
  logic [WAYS_PER_BUCKET-1:0] row_wdata;
  logic [WAYS_PER_BUCKET-1:0] row_rdata;
  logic [ENTRY_BITS-1:0]      entry_addr;
  logic [KEY_W-1:0]           key_wdata;
  logic [IDX_W-1:0]           val_wdata;
  logic [KEY_W-1:0]           key_rdata;
  logic [IDX_W-1:0]           val_rdata;

  logic     res_valid;
  logic     res_ready;
  hlc_out_t res_data;

  logic     out_valid_r;
  hlc_out_t out_data_r;

  hlc_ctrl #(
    .BUCKET_COUNT    (BUCKET_COUNT),
    .WAYS_PER_BUCKET (WAYS_PER_BUCKET)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_data   (res_data),
    .mem_ctl    (mem_ctl),
    .row_addr   (row_addr),
    .row_wdata  (row_wdata),
    .row_rdata  (row_rdata),
    .entry_addr (entry_addr),
    .key_wdata  (key_wdata),
    .val_wdata  (val_wdata),
    .key_rdata  (key_rdata),
    .val_rdata  (val_rdata)
  );

  hlc_store #(
    .BUCKET_COUNT    (BUCKET_COUNT),
    .WAYS_PER_BUCKET (WAYS_PER_BUCKET)
  ) u_store (
    .clk        (clk),
    .mem_ctl    (mem_ctl),
    .row_addr   (row_addr),
    .row_wdata  (row_wdata),
    .row_rdata  (row_rdata),
    .entry_addr (entry_addr),
    .key_wdata  (key_wdata),
    .val_wdata  (val_wdata),
    .key_rdata  (key_rdata),
    .val_rdata  (val_rdata)
  );

  // Output register: load when empty or when the current transaction leaves.
  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Hold the payload while stalled; advance only on a load.
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: hw/rtl/hlc_store.sv
module hlc_store #(
  parameter int unsigned BUCKET_COUNT    = hlc_pkg::BUCKET_COUNT_DEF,
  parameter int unsigned WAYS_PER_BUCKET = hlc_pkg::WAYS_PER_BUCKET_DEF,
  localparam int unsigned BUCKET_BITS    = $clog2(BUCKET_COUNT),
  localparam int unsigned ENTRIES        = BUCKET_COUNT * WAYS_PER_BUCKET,
  localparam int unsigned ENTRY_BITS     = $clog2(ENTRIES)
) (
  input  logic                               clk,
  input  hlc_pkg::hlc_mem_ctl_t              mem_ctl,
  input  logic [BUCKET_BITS-1:0]             row_addr,
  input  logic [WAYS_PER_BUCKET-1:0]         row_wdata,
  output logic [WAYS_PER_BUCKET-1:0]         row_rdata,
  input  logic [ENTRY_BITS-1:0]              entry_addr,
  input  logic [hlc_pkg::KEY_W-1:0]          key_wdata,
  input  logic [hlc_pkg::IDX_W-1:0]          val_wdata,
  output logic [hlc_pkg::KEY_W-1:0]          key_rdata,
  output logic [hlc_pkg::IDX_W-1:0]          val_rdata
);
  import hlc_pkg::*;

  // one row of valid bits per bucket
  logic [WAYS_PER_BUCKET-1:0] row_mem [BUCKET_COUNT];
  logic [KEY_W-1:0]           key_mem [ENTRIES];
  logic [IDX_W-1:0]           val_mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (mem_ctl.row_we) begin
      row_mem[row_addr] <= row_wdata;
    end
    row_rdata <= row_mem[row_addr];
  end

  always_ff @(posedge clk) begin
    if (mem_ctl.entry_we) begin
      key_mem[entry_addr] <= key_wdata;
      val_mem[entry_addr] <= val_wdata;
    end
    key_rdata <= key_mem[entry_addr];
    val_rdata <= val_mem[entry_addr];
  end

endmodule

// File: hw/rtl/hlc_ctrl.sv
module hlc_ctrl #(
  parameter int unsigned BUCKET_COUNT    = hlc_pkg::BUCKET_COUNT_DEF,
  parameter int unsigned WAYS_PER_BUCKET = hlc_pkg::WAYS_PER_BUCKET_DEF,
  localparam int unsigned BUCKET_BITS    = $clog2(BUCKET_COUNT),
  localparam int unsigned ENTRIES        = BUCKET_COUNT * WAYS_PER_BUCKET,
  localparam int unsigned ENTRY_BITS     = $clog2(ENTRIES),
  localparam int unsigned WAY_BITS       = (WAYS_PER_BUCKET > 1) ? $clog2(WAYS_PER_BUCKET) : 1
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  hlc_pkg::hlc_in_t                   in_data,
  output logic                               res_valid,
  input  logic                               res_ready,
  output hlc_pkg::hlc_out_t                  res_data,
  output hlc_pkg::hlc_mem_ctl_t              mem_ctl,
  output logic [BUCKET_BITS-1:0]             row_addr,
  output logic [WAYS_PER_BUCKET-1:0]         row_wdata,
  input  logic [WAYS_PER_BUCKET-1:0]         row_rdata,
  output logic [ENTRY_BITS-1:0]              entry_addr,
  output logic [hlc_pkg::KEY_W-1:0]          key_wdata,
  output logic [hlc_pkg::IDX_W-1:0]          val_wdata,
  input  logic [hlc_pkg::KEY_W-1:0]          key_rdata,
  input  logic [hlc_pkg::IDX_W-1:0]          val_rdata
);
  import hlc_pkg::*;

  localparam bit BUCKET_POW2 = ((BUCKET_COUNT & (BUCKET_COUNT - 1)) == 0);
  // key residue for other bucket counts, one 16-bit chunk at a time
  localparam int unsigned CHUNK_W = 16;
  localparam int unsigned CHUNKS  = KEY_W / CHUNK_W;
  localparam int unsigned HBIT_W  = $clog2(CHUNKS);
  localparam int unsigned X_W     = BUCKET_BITS + CHUNK_W;
  localparam int unsigned Q_W     = CHUNK_W + 1;
  localparam logic [Q_W-1:0] RECIP = Q_W'((64'd1 << X_W) / BUCKET_COUNT);

  hlc_state_t state_r, state_nxt;
  logic [BUCKET_BITS-1:0] clr_r, clr_nxt;

  logic [1:0]             act_r;
  logic [KEY_W-1:0]       key_r;
  logic [IDX_W-1:0]       val_r;
  logic [BUCKET_BITS-1:0] bucket_r;
  logic [HBIT_W-1:0]      hbit_r;
  logic                   hph_r;
  logic [Q_W-1:0]         quo_r;
  logic [WAY_BITS-1:0]    way_r;
  logic [WAY_BITS-1:0]    hit_way_r;
  logic                   hit_r;
  logic [IDX_W-1:0]       found_r;
  hlc_out_t               res_r;

  logic                   accept;
  logic                   last_way;
  logic                   hit_now;
  logic                   row_full;
  logic [WAY_BITS-1:0]    free_way;
  logic [ENTRY_BITS-1:0]  base;
  logic [X_W-1:0]         hash_x;
  logic [X_W+Q_W-1:0]     hash_prod;
  logic [X_W-1:0]         hash_rem;
  logic [BUCKET_BITS:0]   rem_sum;
  logic [BUCKET_BITS:0]   rem_red;
  hlc_out_t               exec_res;

  assign accept   = (state_r == S_IDLE) && in_valid;
  assign last_way = (way_r == WAY_BITS'(WAYS_PER_BUCKET - 1));
  assign hit_now  = row_rdata[way_r] && (key_rdata == key_r);
  assign row_full = &row_rdata;
  assign base     = ENTRY_BITS'(bucket_r) * ENTRY_BITS'(WAYS_PER_BUCKET);

  // one chunk of the residue: rem = (rem * 2^16 + chunk) mod BUCKET_COUNT.
  // The reciprocal gives a quotient that is low by at most one, so a single
  // compare and subtract finishes the step.
  assign hash_x    = {bucket_r, key_r[{hbit_r, 4'b0000} +: CHUNK_W]};
  assign hash_prod = (X_W + Q_W)'(hash_x) * (X_W + Q_W)'(RECIP);
  assign hash_rem  = hash_x - X_W'(quo_r) * X_W'(BUCKET_COUNT);
  assign rem_sum   = hash_rem[BUCKET_BITS:0];
  assign rem_red   = (rem_sum >= (BUCKET_BITS + 1)'(BUCKET_COUNT)) ?
                     rem_sum - (BUCKET_BITS + 1)'(BUCKET_COUNT) : rem_sum;

  // lowest free way of the bucket
  always_comb begin
    free_way = '0;
    for (int i = WAYS_PER_BUCKET - 1; i >= 0; i--) begin
      if (!row_rdata[i]) begin
        free_way = WAY_BITS'(i);
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    unique case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == BUCKET_BITS'(BUCKET_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = BUCKET_POW2 ? S_ROW : S_HASH;
        end
      end
      S_HASH: begin
        if (hph_r && (hbit_r == '0)) begin
          state_nxt = S_ROW;
        end
      end
      S_ROW:   state_nxt = S_ISSUE;
      S_ISSUE: state_nxt = S_CMP;
      S_CMP: begin
        if (hit_now || last_way) begin
          state_nxt = S_EXEC;
        end else begin
          state_nxt = S_ISSUE;
        end
      end
      S_EXEC: state_nxt = S_DONE;
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // outputs and memory control
  always_comb begin
    in_stall   = (state_r != S_IDLE);
    res_valid  = (state_r == S_DONE);
    mem_ctl    = '0;
    row_addr   = bucket_r;
    row_wdata  = row_rdata;
    entry_addr = base + ENTRY_BITS'(way_r);
    exec_res   = '{status: ST_MISS, found_index: '0};
    unique case (state_r)
      S_CLEAR: begin
        mem_ctl.row_we = 1'b1;
        row_addr       = clr_r;
        row_wdata      = '0;
      end
      S_EXEC: begin
        entry_addr = base + ENTRY_BITS'(free_way);
        case (act_r)
          ACT_INSERT: begin
            if (hit_r) begin
              exec_res.status = ST_PRESENT;
            end else if (row_full) begin
              exec_res.status = ST_FULL;
            end else begin
              mem_ctl.row_we   = 1'b1;
              mem_ctl.entry_we = 1'b1;
              row_wdata        = row_rdata | (WAYS_PER_BUCKET'(1) << free_way);
              exec_res.status  = ST_OK;
            end
          end
          ACT_LOOKUP: begin
            if (hit_r) begin
              exec_res.status      = ST_OK;
              exec_res.found_index = found_r;
            end
          end
          ACT_DELETE: begin
            if (hit_r) begin
              mem_ctl.row_we  = 1'b1;
              row_wdata       = row_rdata & ~(WAYS_PER_BUCKET'(1) << hit_way_r);
              exec_res.status = ST_OK;
            end
          end
          default: exec_res.status = ST_MISS;
        endcase
      end
      S_IDLE, S_HASH, S_ROW, S_ISSUE, S_CMP, S_DONE: begin
        row_addr = bucket_r;
      end
      default: row_addr = bucket_r;
    endcase
  end

  assign key_wdata = key_r;
  assign val_wdata = val_r;
  assign res_data  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r  <= in_data.action;
      key_r  <= in_data.seq_key;
      val_r  <= in_data.server_index;
      hbit_r <= HBIT_W'(CHUNKS - 1);
      hph_r  <= 1'b0;
      if (BUCKET_POW2) begin
        bucket_r <= in_data.seq_key[BUCKET_BITS-1:0];
      end else begin
        bucket_r <= '0;
      end
    end
    if (state_r == S_HASH) begin
      hph_r <= !hph_r;
      if (!hph_r) begin
        quo_r <= hash_prod[X_W +: Q_W];
      end else begin
        bucket_r <= rem_red[BUCKET_BITS-1:0];
        hbit_r   <= hbit_r - 1'b1;
      end
    end
    if (state_r == S_ROW) begin
      way_r <= '0;
      hit_r <= 1'b0;
    end
    if (state_r == S_CMP) begin
      if (hit_now) begin
        hit_r     <= 1'b1;
        hit_way_r <= way_r;
        found_r   <= val_rdata;
      end else if (!last_way) begin
        way_r <= way_r + 1'b1;
      end
    end
    if (state_r == S_EXEC) begin
      res_r <= exec_res;
    end
  end

endmodule

// File: hw/rtl/hlc_checker.sv
`include "assert_macros.svh"

module hlc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input hlc_pkg::hlc_out_t out_data
);
  import hlc_pkg::*;

  `HLC_ASSERT(a_out_hold_valid, clk, rst_n, out_valid && out_stall |=> out_valid)
  `HLC_ASSERT(a_out_hold_data, clk, rst_n, out_valid && out_stall |=> $stable(out_data))
  `HLC_ASSERT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall |=> in_stall)
  `HLC_ASSERT(a_index_only_on_ok, clk, rst_n, out_valid && out_data.status != ST_OK |-> out_data.found_index == '0)
  `HLC_ASSERT_NORST(a_reset_quiet, clk, !rst_n |=> in_stall && !out_valid)

endmodule

bind hashed_location_cache_top hlc_checker u_hlc_checker (.*);
